// ----- rtl/core/bwmc_pkg.sv -----
// Package for the burst window max count block: item and result types,
// sequencer states, config register indexes and fixed field widths.
// No dependencies.
`default_nettype none

package bwmc_pkg;

    localparam int TS_W   = 64;
    localparam int SEV_W  = 3;
    localparam int CNT_W  = 9;
    localparam int WSEC_W = 32;
    localparam int MCNT_W = 16;
    // 32-bit seconds times 1e6 needs 52 bits, so the window never saturates
    localparam int WIN_W  = 52;

    localparam logic [19:0] MICROS_PER_SEC = 20'd1000000;

    localparam logic [1:0] CFG_WINDOW_SECONDS = 2'd0;
    localparam logic [1:0] CFG_MIN_COUNT      = 2'd1;
    localparam logic [1:0] CFG_MIN_SEVERITY   = 2'd2;

    localparam logic [WSEC_W-1:0] WINDOW_SECONDS_RST = 32'd60;
    localparam logic [MCNT_W-1:0] MIN_COUNT_RST      = 16'd50;
    localparam logic [SEV_W-1:0]  MIN_SEVERITY_RST   = 3'd3;

    typedef struct packed {
        logic             ts_valid;
        logic [TS_W-1:0]  ts_micros;
        logic [SEV_W-1:0] severity;
        logic             last;
    } item_t;

    typedef struct packed {
        logic             overflowed;
        logic [TS_W-1:0]  window_last_micros;
        logic [TS_W-1:0]  window_first_micros;
        logic [CNT_W-1:0] burst_count;
        logic             detected;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SCAN,
        ST_REPORT
    } seq_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/bwmc_store.sv -----
// Timestamp store of the window FIFO: one write port, one registered read
// port with write-to-read forwarding. Depends on bwmc_pkg.
`default_nettype none

module bwmc_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic [bwmc_pkg::TS_W-1:0] wr_data,
    input  wire logic [AW-1:0]            rd_addr,
    output logic      [bwmc_pkg::TS_W-1:0] rd_data
);
    import bwmc_pkg::*;

    logic [TS_W-1:0] mem [DEPTH];
    logic [TS_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a push into an empty FIFO is read back on the very next cycle
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bwmc_span_cmp.sv -----
// Shared span compare: is newest - oldest (signed) beyond the
// window length. Used once per scan cycle. Depends on bwmc_pkg.
`default_nettype none

module bwmc_span_cmp (
    input  wire logic [bwmc_pkg::TS_W-1:0]  newest,
    input  wire logic [bwmc_pkg::TS_W-1:0]  oldest,
    input  wire logic [bwmc_pkg::WIN_W-1:0] win,
    output logic                            too_far
);
    import bwmc_pkg::*;

    logic [TS_W:0] diff;

    // 65-bit signed difference; a set top bit means newest is older
    assign diff    = {newest[TS_W-1], newest} - {oldest[TS_W-1], oldest};
    assign too_far = !diff[TS_W] && (diff[TS_W-1:0] > TS_W'(win));

endmodule

`default_nettype wire

// ----- rtl/core/bwmc_seq.sv -----
// Sequencer of the burst window block: FIFO pointers, push, pop loop over
// the shared span compare, best-window tracking and the report.
// Depends on bwmc_pkg, bwmc_store and bwmc_span_cmp.
`default_nettype none

module bwmc_seq #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int CW    = 9
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire bwmc_pkg::item_t             item,
    input  wire logic [bwmc_pkg::SEV_W-1:0]  min_severity,
    input  wire logic [bwmc_pkg::MCNT_W-1:0] min_count,
    input  wire logic [bwmc_pkg::WIN_W-1:0]  win,
    input  wire logic                        out_free,
    output logic                             res_load,
    output bwmc_pkg::result_t                result,
    output logic [CW-1:0]                    occupancy
);
    import bwmc_pkg::*;

    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] OCC_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] OCC_ONE  = CW'(1);

    seq_state_t       state_reg, state_next;
    item_t            item_reg, item_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    occ_reg, occ_next;
    logic [CW-1:0]    best_count_reg, best_count_next;
    logic [TS_W-1:0]  best_first_reg, best_first_next;
    logic [TS_W-1:0]  best_last_reg, best_last_next;
    logic             ovf_reg, ovf_next;

    logic             wr_en;
    logic [TS_W-1:0]  oldest;
    logic             too_far;
    logic             qualify;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + AW'(1);
    endfunction

    bwmc_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (item_reg.ts_micros),
        .rd_addr (head_next),
        .rd_data (oldest)
    );

    bwmc_span_cmp u_span_cmp (
        .newest  (item_reg.ts_micros),
        .oldest  (oldest),
        .win     (win),
        .too_far (too_far)
    );

    assign qualify = item_reg.ts_valid && (item_reg.severity <= min_severity);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            occ_reg        <= '0;
            best_count_reg <= '0;
            best_first_reg <= '0;
            best_last_reg  <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            occ_reg        <= occ_next;
            best_count_reg <= best_count_next;
            best_first_reg <= best_first_next;
            best_last_reg  <= best_last_next;
            ovf_reg        <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        best_count_next = best_count_reg;
        best_first_next = best_first_reg;
        best_last_next  = best_last_reg;
        ovf_next        = ovf_reg;
        wr_en           = 1'b0;
        res_load        = 1'b0;
        item_ready      = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    item_next  = item;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (qualify) begin
                    // full: drop the oldest word, count stays at DEPTH
                    if (occ_reg == OCC_FULL) begin
                        head_next = ptr_inc(head_reg);
                        ovf_next  = 1'b1;
                    end else begin
                        occ_next = occ_reg + OCC_ONE;
                    end
                    wr_en      = 1'b1;
                    tail_next  = ptr_inc(tail_reg);
                    state_next = ST_SCAN;
                end else begin
                    state_next = item_reg.last ? ST_REPORT : ST_IDLE;
                end
            end
            ST_SCAN: begin
                if ((occ_reg > OCC_ONE) && too_far) begin
                    head_next = ptr_inc(head_reg);
                    occ_next  = occ_reg - OCC_ONE;
                end else begin
                    if (occ_reg > best_count_reg) begin
                        best_count_next = occ_reg;
                        best_first_next = oldest;
                        best_last_next  = item_reg.ts_micros;
                    end
                    state_next = item_reg.last ? ST_REPORT : ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    res_load        = 1'b1;
                    head_next       = '0;
                    tail_next       = '0;
                    occ_next        = '0;
                    best_count_next = '0;
                    best_first_next = '0;
                    best_last_next  = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        result.detected            = (min_count != '0) &&
                                     (32'(best_count_reg) >= 32'(min_count));
        result.burst_count         = CNT_W'(best_count_reg);
        result.window_first_micros = best_first_reg;
        result.window_last_micros  = best_last_reg;
        result.overflowed          = ovf_reg;
    end

    assign occupancy = occ_reg;

endmodule

`default_nettype wire

// ----- rtl/core/burst_window_max_count.sv -----
// Top level of the burst window max count block: stream ports, config
// registers, window length multiply and the result register.
// Depends on bwmc_pkg and bwmc_seq.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+----------------------------------------
//  s_       | in  | s_tvalid/s_tready | tdata ts_micros, severity; tuser ts_valid;
//           |     |                   | tlast last
//  m_       | out | m_tvalid/m_tready | tdata detected, burst_count, first, last,
//           |     |                   | overflowed
//  cfg_     | in  | cfg_valid/ready   | cfg_index, cfg_data
//
// Steps: a word that does not qualify passes ST_IDLE and ST_PUSH; a qualifying
// word passes ST_IDLE, ST_PUSH and ST_SCAN, which pops entries one per cycle
// through the span compare and the store's single read port. A last word adds
// ST_REPORT for the report, held there while m_tready holds it off. s_tready is high only
// between words. aresetn is synchronous; the store needs no clearing pass.
// Config writes are taken every cycle; win_reg then registers the window product.
`default_nettype none

module burst_window_max_count #(
    parameter int DEPTH = 256
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,  // ts_micros[63:0], severity[66:64], zero pad
    input  wire logic         s_tuser,  // ts_valid
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata,  // detected, burst_count[9:1], first[73:10],
                                        // last[137:74], overflowed[138], zero pad
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import bwmc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WSEC_W-1:0] window_seconds_reg, window_seconds_next;
    logic [MCNT_W-1:0] min_count_reg, min_count_next;
    logic [SEV_W-1:0]  min_severity_reg, min_severity_next;
    logic [WIN_W-1:0]  win_reg;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [143:0]      m_tdata_reg;

    item_t             item;
    result_t           result;
    logic              res_load;
    logic              out_free;
    logic [CW-1:0]     occupancy;

    assign cfg_ready = 1'b1;

    always_comb begin
        window_seconds_next = window_seconds_reg;
        min_count_next      = min_count_reg;
        min_severity_next   = min_severity_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_WINDOW_SECONDS: window_seconds_next = cfg_data;
                CFG_MIN_COUNT:      min_count_next      = cfg_data[MCNT_W-1:0];
                CFG_MIN_SEVERITY:   min_severity_next   = cfg_data[SEV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_seconds_reg <= WINDOW_SECONDS_RST;
            min_count_reg      <= MIN_COUNT_RST;
            min_severity_reg   <= MIN_SEVERITY_RST;
            m_tvalid_reg       <= 1'b0;
        end else begin
            window_seconds_reg <= window_seconds_next;
            min_count_reg      <= min_count_next;
            min_severity_reg   <= min_severity_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    // window in microseconds, 32 x 20 bit product
    always_ff @(posedge aclk) begin
        win_reg <= WIN_W'(window_seconds_reg) * WIN_W'(MICROS_PER_SEC);
    end

    assign item.ts_valid  = s_tuser;
    assign item.ts_micros = s_tdata[63:0];
    assign item.severity  = s_tdata[66:64];
    assign item.last      = s_tlast;

    bwmc_seq #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (s_tvalid),
        .item_ready   (s_tready),
        .item         (item),
        .min_severity (min_severity_reg),
        .min_count    (min_count_reg),
        .win          (win_reg),
        .out_free     (out_free),
        .res_load     (res_load),
        .result       (result),
        .occupancy    (occupancy)
    );

    assign out_free      = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = res_load || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_tdata_reg <= {5'b0, result};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= CW'(DEPTH))
        else $error("window occupancy above depth");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untaken word");

    a_clear_after_report: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> (occupancy == '0) && s_tready)
        else $error("state not cleared after report");

endmodule

`default_nettype wire
